FILE: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Step segment planner package
// Field widths, arithmetic widths and register indexes shared by the planner
// core, its serial divider and its port checker.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Motors and splitting.
  localparam int MOTORS    = 16;
  localparam int MOTOR_W   = 4;
  localparam int SPLIT_LOG = 5;             // a segment repeats at most 2**5 times

  // Field widths.
  localparam int POS_W   = 24;
  localparam int DELTA_W = POS_W + 1;
  localparam int MS_W    = 16;
  localparam int CLK_W   = 27;
  localparam int DIVR_W  = 15;
  localparam int STEP_W  = 12;
  localparam int MAG_W   = STEP_W + SPLIT_LOG;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = CLK_W;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_INVERT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIV    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS  = 2'd3;

  // Reset values of the registers.
  localparam logic [CLK_W-1:0]  CLOCK_HZ_RST  = 27'd25000000;
  localparam logic [DIVR_W-1:0] MAX_DIV_RST   = 15'd32767;
  localparam logic [STEP_W-1:0] MAX_STEPS_RST = 12'd4095;

  // Serial arithmetic.
  localparam int MS_PER_S = 1000;
  localparam int MUL_W    = MAG_W;          // multiplier operand, bit-serial
  localparam int PROD_W   = 43;             // covers clock_hz * move_msecs
  localparam int DEN_W    = CLK_W;          // widest divisor
  localparam int MCNT_W   = $clog2(MUL_W + 1);
  localparam int DCNT_W   = $clog2(PROD_W + 1);

endpackage

FILE: rtl/ssp_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, shared by the three
// divisions of the planner.
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ssp_pkg::PROD_W-1:0]      dividend,
  input  logic [ssp_pkg::DEN_W-1:0]       divisor,
  output logic                            done,
  output logic [ssp_pkg::PROD_W-1:0]      quotient
);

  logic [ssp_pkg::DEN_W:0]    rem;
  logic [ssp_pkg::PROD_W-1:0] quo;
  logic [ssp_pkg::DCNT_W-1:0] cnt;
  logic [ssp_pkg::DEN_W:0]    rem_shift;
  logic                       fits;

  // The dividend shifts out of the top of quo while quotient bits enter below.
  assign rem_shift = {rem[ssp_pkg::DEN_W-1:0], quo[ssp_pkg::PROD_W-1]};
  assign fits      = rem_shift >= {1'b0, divisor};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= ssp_pkg::DCNT_W'(ssp_pkg::PROD_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == ssp_pkg::DCNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (cnt != '0) begin
      rem <= fits ? (rem_shift - {1'b0, divisor}) : rem_shift;
      quo <= {quo[ssp_pkg::PROD_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/step_segment_planner_core.sv
// ----------------------------------------------------------------------------
// Step segment planner core
// Turns a move request into step segments (direction, steps, clock divider),
// plus a trailing wait segment when a clamped divider leaves time over.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  --------  ---------------------  -------------------------------------------
//  request   in_valid / in_stall    motor_index, target_position, move_msecs,
//                                   queue_empty, current_position
//  segment   out_valid / out_stall  motor_number, direction, step_count,
//                                   divider, is_wait, duration_ms, saturated,
//                                   last
//  config    cfg_write              cfg_index, cfg_data (no read-back)
//
// One request is worked at a time. The work is done by the bit-serial
// multiplier, which runs once or three times per moving request, and the
// shared serial divider, which runs two or three times; the third passes
// come only when the divider is clamped and the wait time must be found.
// A synchronous reset returns the sequencer and configuration registers
// to their reset values and clears every motor's last target.
// A stall on the segment side holds the current beat; no new request is
// taken until the last segment beat of the present one has left.

module step_segment_planner_core (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ssp_pkg::MOTOR_W-1:0]       motor_index,
  input  logic signed [ssp_pkg::POS_W-1:0]  target_position,
  input  logic [ssp_pkg::MS_W-1:0]          move_msecs,
  input  logic                              queue_empty,
  input  logic signed [ssp_pkg::POS_W-1:0]  current_position,
  // segment channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssp_pkg::MOTOR_W-1:0]       motor_number,
  output logic                              direction,
  output logic [ssp_pkg::STEP_W-1:0]        step_count,
  output logic [ssp_pkg::DIVR_W-1:0]        divider,
  output logic                              is_wait,
  output logic [ssp_pkg::MS_W-1:0]          duration_ms,
  output logic                              saturated,
  output logic                              last
);

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_MAG    = 13'b0000000000010,
    ST_SAT    = 13'b0000000000100,
    ST_MUL1   = 13'b0000000001000,
    ST_DIV1   = 13'b0000000010000,
    ST_DIV2   = 13'b0000000100000,
    ST_CLAMP  = 13'b0000001000000,
    ST_MUL2   = 13'b0000010000000,
    ST_MUL3   = 13'b0000100000000,
    ST_DIV3   = 13'b0001000000000,
    ST_REMAIN = 13'b0010000000000,
    ST_SPLIT  = 13'b0100000000000,
    ST_EMIT   = 13'b1000000000000
  } state_t;

  localparam logic [ssp_pkg::MUL_W-1:0]  MS_PER_S_MUL = ssp_pkg::MUL_W'(ssp_pkg::MS_PER_S);
  localparam logic [ssp_pkg::DEN_W-1:0]  MS_PER_S_DEN = ssp_pkg::DEN_W'(ssp_pkg::MS_PER_S);
  localparam logic [ssp_pkg::MCNT_W-1:0] MUL_STEPS    = ssp_pkg::MCNT_W'(ssp_pkg::MUL_W);
  localparam int                         SPLIT_CNT_W  = $clog2(ssp_pkg::SPLIT_LOG + 1);
  localparam int                         REPS_W       = ssp_pkg::SPLIT_LOG + 1;

  // Configuration registers.
  logic [ssp_pkg::CLK_W-1:0]  clock_hz;
  logic                       direction_invert;
  logic [ssp_pkg::DIVR_W-1:0] max_div;
  logic [ssp_pkg::STEP_W-1:0] max_steps;

  // Per-motor last target.
  logic signed [ssp_pkg::POS_W-1:0] last_target [ssp_pkg::MOTORS];

  state_t state;

  // Request and segment registers.
  logic [ssp_pkg::MOTOR_W-1:0]        mi;
  logic [ssp_pkg::MS_W-1:0]           ms;
  logic signed [ssp_pkg::DELTA_W-1:0] delta;
  logic [ssp_pkg::POS_W-1:0]          mag;
  logic [ssp_pkg::MAG_W-1:0]          steps;
  logic [SPLIT_CNT_W-1:0]             split_cnt;
  logic [REPS_W-1:0]                  reps_left;
  logic [ssp_pkg::DIVR_W-1:0]         divv;
  logic [ssp_pkg::MS_W-1:0]           wait_ms;
  logic                               dir;
  logic                               sat;
  logic                               wait_beat;

  // Bit-serial multiplier.
  logic [ssp_pkg::PROD_W-1:0]         mcand;
  logic [ssp_pkg::MUL_W-1:0]          mplier;
  logic [ssp_pkg::PROD_W-1:0]         acc;
  logic [ssp_pkg::MCNT_W-1:0]         mcnt;

  // Shared divider.
  logic                               div_start;
  logic                               div_done;
  logic [ssp_pkg::PROD_W-1:0]         div_dividend;
  logic [ssp_pkg::DEN_W-1:0]          div_divisor;
  logic [ssp_pkg::PROD_W-1:0]         div_quo;

  logic                               in_accept;
  logic                               out_accept;
  logic [ssp_pkg::STEP_W-1:0]         lim;
  logic [ssp_pkg::MAG_W-1:0]          cap;
  logic signed [ssp_pkg::POS_W-1:0]   ref_pos;
  logic [ssp_pkg::DELTA_W-1:0]        delta_neg;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // A zero step limit acts as one; the magnitude is capped at 2**SPLIT_LOG * limit.
  assign lim = (max_steps == '0) ? ssp_pkg::STEP_W'(1) : max_steps;
  assign cap = ssp_pkg::MAG_W'(lim) << ssp_pkg::SPLIT_LOG;

  assign ref_pos   = queue_empty ? current_position : last_target[motor_index];
  assign delta_neg = -delta;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz         <= ssp_pkg::CLOCK_HZ_RST;
      direction_invert <= 1'b0;
      max_div          <= ssp_pkg::MAX_DIV_RST;
      max_steps        <= ssp_pkg::MAX_STEPS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssp_pkg::REG_CLOCK_HZ:   clock_hz         <= cfg_data[ssp_pkg::CLK_W-1:0];
        ssp_pkg::REG_DIR_INVERT: direction_invert <= cfg_data[0];
        ssp_pkg::REG_MAX_DIV:    max_div          <= cfg_data[ssp_pkg::DIVR_W-1:0];
        ssp_pkg::REG_MAX_STEPS:  max_steps        <= cfg_data[ssp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // The request's target becomes the motor's last target as it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ssp_pkg::MOTORS; i++) begin
        last_target[i] <= '0;
      end
    end else if (in_accept) begin
      last_target[motor_index] <= target_position;
    end
  end

  // Divider operands follow the state that owns the division.
  always_comb begin
    div_dividend = acc;
    div_divisor  = MS_PER_S_DEN;
    if (state == ST_DIV2) begin
      div_divisor = ssp_pkg::DEN_W'(mag);
    end else if (state == ST_DIV3) begin
      div_divisor = clock_hz;
    end
  end

  ssp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          // A zero delta yields no segment.
          state <= (delta == '0) ? ST_IDLE : ST_SAT;
        end
        ST_SAT: begin
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          if (mcnt == ssp_pkg::MCNT_W'(1)) begin
            state     <= ST_DIV1;
            div_start <= 1'b1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            state     <= ST_DIV2;
            div_start <= 1'b1;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (acc > ssp_pkg::PROD_W'(max_div) && clock_hz != '0) begin
            state <= ST_MUL2;
          end else begin
            state <= ST_SPLIT;
          end
        end
        ST_MUL2: begin
          if (mcnt == ssp_pkg::MCNT_W'(1)) begin
            state <= ST_MUL3;
          end
        end
        ST_MUL3: begin
          if (mcnt == ssp_pkg::MCNT_W'(1)) begin
            state     <= ST_DIV3;
            div_start <= 1'b1;
          end
        end
        ST_DIV3: begin
          if (div_done) begin
            state <= ST_REMAIN;
          end
        end
        ST_REMAIN: begin
          state <= ST_SPLIT;
        end
        ST_SPLIT: begin
          if (!(steps > ssp_pkg::MAG_W'(lim) &&
                split_cnt != SPLIT_CNT_W'(ssp_pkg::SPLIT_LOG))) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_accept && (wait_beat || (reps_left == REPS_W'(1) && wait_ms == '0))) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          mi    <= motor_index;
          ms    <= move_msecs;
          delta <= ssp_pkg::DELTA_W'(target_position) - ssp_pkg::DELTA_W'(ref_pos);
        end
      end
      ST_MAG: begin
        mag <= delta[ssp_pkg::DELTA_W-1] ? delta_neg[ssp_pkg::POS_W-1:0]
                                         : delta[ssp_pkg::POS_W-1:0];
        dir <= !delta[ssp_pkg::DELTA_W-1] ^ direction_invert;
      end
      ST_SAT: begin
        // Clamp the magnitude and start clock_hz * move_msecs.
        if (mag > ssp_pkg::POS_W'(cap)) begin
          mag <= ssp_pkg::POS_W'(cap);
          sat <= 1'b1;
        end else begin
          sat <= 1'b0;
        end
        steps     <= (mag > ssp_pkg::POS_W'(cap)) ? cap : mag[ssp_pkg::MAG_W-1:0];
        split_cnt <= '0;
        mcand     <= ssp_pkg::PROD_W'(clock_hz);
        mplier    <= ssp_pkg::MUL_W'(ms);
        acc       <= '0;
        mcnt      <= MUL_STEPS;
      end
      ST_MUL1, ST_MUL2, ST_MUL3: begin
        acc    <= acc + (mplier[0] ? mcand : '0);
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        mcnt   <= mcnt - 1'b1;
        // At the end of max_div * magnitude, chain into the product times 1000.
        if (state == ST_MUL2 && mcnt == ssp_pkg::MCNT_W'(1)) begin
          mcand  <= '0;
          mplier <= MS_PER_S_MUL;
          mcnt   <= MUL_STEPS;
          mcand  <= acc + (mplier[0] ? mcand : '0);
          acc    <= '0;
        end
      end
      ST_DIV1, ST_DIV2, ST_DIV3: begin
        if (div_done) begin
          acc <= div_quo;
        end
      end
      ST_CLAMP: begin
        wait_ms <= '0;
        if (acc > ssp_pkg::PROD_W'(max_div)) begin
          divv   <= max_div;
          // Time actually covered is max_div * magnitude * 1000 / clock_hz.
          mcand  <= ssp_pkg::PROD_W'(max_div);
          mplier <= mag[ssp_pkg::MAG_W-1:0];
          acc    <= '0;
          mcnt   <= MUL_STEPS;
        end else begin
          divv <= acc[ssp_pkg::DIVR_W-1:0];
        end
      end
      ST_REMAIN: begin
        if (acc < ssp_pkg::PROD_W'(ms)) begin
          wait_ms <= ms - acc[ssp_pkg::MS_W-1:0];
        end
      end
      ST_SPLIT: begin
        if (steps > ssp_pkg::MAG_W'(lim) &&
            split_cnt != SPLIT_CNT_W'(ssp_pkg::SPLIT_LOG)) begin
          steps     <= steps >> 1;
          split_cnt <= split_cnt + 1'b1;
        end else begin
          if (steps > ssp_pkg::MAG_W'(lim)) begin
            steps <= ssp_pkg::MAG_W'(lim);
          end
          reps_left <= REPS_W'(1) << split_cnt;
          wait_beat <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_accept && !wait_beat) begin
          if (reps_left == REPS_W'(1)) begin
            wait_beat <= 1'b1;
          end else begin
            reps_left <= reps_left - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Segment beat, held steady by registers while stalled.
  assign in_stall     = (state != ST_IDLE);
  assign out_valid    = (state == ST_EMIT);
  assign motor_number = mi;
  assign direction    = dir;
  assign step_count   = wait_beat ? '0 : steps[ssp_pkg::STEP_W-1:0];
  assign divider      = divv;
  assign is_wait      = wait_beat;
  assign duration_ms  = wait_beat ? wait_ms : ms;
  assign saturated    = sat;
  assign last         = wait_beat || (reps_left == REPS_W'(1) && wait_ms == '0);

endmodule

FILE: rtl/ssp_check.sv
// ----------------------------------------------------------------------------
// Step segment planner port checker
// Watches the planner's ports for beats that break its segment rules.
// ----------------------------------------------------------------------------
module ssp_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        out_valid,
  input  logic [ssp_pkg::STEP_W-1:0]  step_count,
  input  logic                        is_wait,
  input  logic                        last
);

  // Segments are only produced while a request is being worked.
  a_no_out_when_open: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("segment beat while the request side is open");

  // A taken request closes the request side on the next cycle.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request side still open after a request was taken");

  // The wait segment is always the final beat of its request.
  a_wait_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_wait |-> last)
    else $error("wait segment not marked last");

  a_wait_no_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_wait |-> step_count == '0)
    else $error("wait segment carries steps");

  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_wait |-> step_count != '0)
    else $error("step segment with no steps");

endmodule

bind step_segment_planner_core ssp_check u_ssp_check (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .step_count (step_count),
  .is_wait    (is_wait),
  .last       (last)
);
